// ===== rtl/core/mbps_pkg.sv =====
// mbps_pkg: shared types, constants and helpers of the masked byte pattern search
// no dependencies; imported by every module under rtl/core
`default_nettype none

package mbps_pkg;

  localparam int unsigned PatternMax = 32;
  localparam int unsigned IdxW       = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned LenW       = $clog2(PatternMax + 1);
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ElemW      = 5;
  localparam int unsigned CfgW       = 6;
  localparam int unsigned CountW     = 32;

  typedef enum logic {
    ModeLoad = 1'b0,
    ModeScan = 1'b1
  } mode_e;

  typedef logic [PatternMax-1:0][ByteW-1:0] byte_row_t;
  typedef logic [PatternMax-1:0]            mask_row_t;

  typedef struct packed {
    logic             write;
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] data;
    logic             wild;
  } load_ctrl_t;

  typedef struct packed {
    logic             shift;
    logic             clear;
    logic [ByteW-1:0] data;
  } win_ctrl_t;

  typedef struct packed {
    mode_e             mode;
    logic [ElemW-1:0]  idx;
    logic [ByteW-1:0]  data;
    logic              wild;
    logic              last;
  } beat_t;

  // zero acts as one, anything above the store depth acts as the depth
  function automatic logic [LenW-1:0] clamp_len(input logic [CfgW-1:0] raw);
    logic [CfgW:0] wide;
    wide = {1'b0, raw};
    if (wide == '0) begin
      clamp_len = LenW'(1);
    end else if (wide > (CfgW + 1)'(PatternMax)) begin
      clamp_len = LenW'(PatternMax);
    end else begin
      clamp_len = LenW'(wide);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mbps_pattern_store.sv =====
// mbps_pattern_store: pattern bytes and wildcard flags, presented aligned to window taps
// depends on mbps_pkg
`default_nettype none

module mbps_pattern_store (
  input  wire logic                    clk_i,
  input  wire mbps_pkg::load_ctrl_t    load_i,
  input  wire logic [mbps_pkg::LenW-1:0] len_i,
  output mbps_pkg::byte_row_t          exp_o,
  output mbps_pkg::mask_row_t          care_o
);
  import mbps_pkg::*;

  logic [ByteW-1:0] pat_q  [PatternMax];
  logic             wild_q [PatternMax];

  always_ff @(posedge clk_i) begin
    if (load_i.write) begin
      pat_q[load_i.idx]  <= load_i.data;
      wild_q[load_i.idx] <= load_i.wild;
    end
  end

  // tap k (k = 0 newest byte) meets pattern position len - 1 - k
  always_comb begin
    logic [LenW-1:0] j;
    for (int unsigned k = 0; k < PatternMax; k++) begin
      j = len_i - LenW'(1) - LenW'(k);
      exp_o[k]  = pat_q[j[IdxW-1:0]];
      care_o[k] = (LenW'(k) < len_i) && !wild_q[j[IdxW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mbps_window_match.sv =====
// mbps_window_match: byte shift window and parallel masked compare against the pattern
// depends on mbps_pkg
`default_nettype none

module mbps_window_match (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mbps_pkg::win_ctrl_t  ctrl_i,
  input  wire mbps_pkg::byte_row_t  exp_i,
  input  wire mbps_pkg::mask_row_t  care_i,
  output logic                      match_o
);
  import mbps_pkg::*;

  byte_row_t win_q;
  byte_row_t shifted;
  mask_row_t tap_ok;

  always_comb begin
    shifted = {win_q[PatternMax-2:0], ctrl_i.data};
    for (int unsigned k = 0; k < PatternMax; k++) begin
      tap_ok[k] = !care_i[k] || (exp_i[k] == shifted[k]);
    end
    match_o = &tap_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q <= ctrl_i.clear ? '0 : shifted;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/masked_byte_pattern_search.sv =====
// masked_byte_pattern_search: top level with beat register, region counters and result register
// depends on mbps_pkg, mbps_pattern_store, mbps_window_match
// Every input beat is taken into an input register and executed once the result register
// is free or being read: a load beat writes one pattern byte and wildcard flag, a scan beat
// shifts one data byte into a 32-byte window that is compared combinationally with the first
// pattern_length pattern bytes. One beat per cycle is sustained while results are taken.
// A result is written into the output register when its beat executes. Each
// region gives exactly one result: found=1 with the start offset at the first match, or
// found=0 on its last byte. Pattern entries read before being loaded return garbage;
// there is no clearing pass after reset. Write pattern_length only while the block is idle.
`default_nettype none

module masked_byte_pattern_search (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mbps_pkg::CfgW-1:0]    cfg_pattern_length_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic [mbps_pkg::ElemW-1:0]   element_index_i,
  input  wire logic [mbps_pkg::ByteW-1:0]   byte_value_i,
  input  wire logic                         wildcard_req_i,
  input  wire logic                         last_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              found_o,
  output logic [mbps_pkg::CountW-1:0]       match_offset_o
);
  import mbps_pkg::*;

  logic                 len_valid_unused;
  logic [LenW-1:0]      len_q;
  logic                 in_valid_q;
  beat_t                beat_q;
  logic [CountW-1:0]    seen_q, seen_d;
  logic                 reported_q, reported_d;
  logic                 out_valid_q, out_valid_d;
  logic                 found_q, found_d;
  logic [CountW-1:0]    offset_q, offset_d;

  logic                 exec, scan, sat, enough, match, hit, miss_end;
  logic [LenW-1:0]      sub;
  logic [CountW:0]      diff;
  load_ctrl_t           load_ctrl;
  win_ctrl_t            win_ctrl;
  byte_row_t            exp_row;
  mask_row_t            care_row;

  assign len_valid_unused = 1'b0;

  assign exec       = in_valid_q && (!out_valid_q || out_ready_i);
  assign scan       = exec && (beat_q.mode == ModeScan) && !len_valid_unused;
  assign in_ready_o = !in_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
    end else if (cfg_we_i) begin
      len_q <= clamp_len(cfg_pattern_length_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= '{mode: mode_e'(mode_i), idx: element_index_i, data: byte_value_i,
                  wild: wildcard_req_i, last: last_byte_i};
    end
  end

  always_comb begin
    load_ctrl.write = exec && (beat_q.mode == ModeLoad) &&
                      ((ElemW + 1)'(beat_q.idx) < (ElemW + 1)'(PatternMax));
    load_ctrl.idx   = IdxW'(beat_q.idx);
    load_ctrl.data  = beat_q.data;
    load_ctrl.wild  = beat_q.wild;
    win_ctrl.shift  = scan;
    win_ctrl.clear  = beat_q.last;
    win_ctrl.data   = beat_q.data;
  end

  mbps_pattern_store u_store (
    .clk_i  (clk_i),
    .load_i (load_ctrl),
    .len_i  (len_q),
    .exp_o  (exp_row),
    .care_o (care_row)
  );

  mbps_window_match u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .exp_i   (exp_row),
    .care_i  (care_row),
    .match_o (match)
  );

  // offset = count after this byte minus len; no borrow means the region holds len bytes
  always_comb begin
    sat      = &seen_q;
    sub      = sat ? len_q : (len_q - LenW'(1));
    diff     = {1'b0, seen_q} - (CountW + 1)'(sub);
    enough   = !diff[CountW];
    hit      = scan && !reported_q && enough && match;
    miss_end = scan && beat_q.last && !reported_q && !hit;
  end

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (scan) begin
      if (beat_q.last) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        seen_d     = sat ? seen_q : (seen_q + CountW'(1));
        reported_d = reported_q || hit;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    offset_d    = offset_q;
    if (hit || miss_end) begin
      out_valid_d = 1'b1;
      found_d     = hit;
      offset_d    = hit ? diff[CountW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  a_hit_sets_reported : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit && !beat_q.last |=> reported_q)
    else $error("match did not mark the region as reported");

  a_last_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan && beat_q.last |=> (seen_q == '0) && !reported_q)
    else $error("last byte did not restart the search");

  a_one_result_per_region : assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> !hit && !miss_end)
    else $error("second result in one region");

  a_load_keeps_scan_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (beat_q.mode == ModeLoad) |=> $stable(seen_q) && $stable(reported_q))
    else $error("load beat changed the scan state");

  a_result_waits_for_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !exec)
    else $error("beat executed while the result register was blocked");

endmodule

`default_nettype wire

// ===== test/masked_byte_pattern_search_tb.sv =====
// masked_byte_pattern_search_tb: self-checking bench for the masked byte pattern search
// depends on mbps_pkg and masked_byte_pattern_search; valid/ready driver, sink and scoreboard
// with an in-bench search predictor, directed beats first, then random regions per length
`default_nettype none

module masked_byte_pattern_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int unsigned ScansPerPhase = 150;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned NumPhases     = 10;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] offset;
  } match_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgW-1:0]      cfg_pattern_length_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i = 1'b0;
  logic [ElemW-1:0]     element_index_i = '0;
  logic [ByteW-1:0]     byte_value_i = '0;
  logic                 wildcard_req_i = 1'b0;
  logic                 last_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 found_o;
  logic [CountW-1:0]    match_offset_o;

  // predictor state
  logic [ByteW-1:0]     sig_bytes [PatternMax];
  logic                 sig_wild  [PatternMax];
  logic [ByteW-1:0]     window_q  [PatternMax];
  logic [CountW-1:0]    seen_q;
  logic                 reported_q;
  logic [CfgW-1:0]      sig_len_q;

  // generator view of the loaded pattern
  logic [ByteW-1:0]     gen_bytes [PatternMax];
  logic                 gen_wild  [PatternMax];

  beat_t                beat_q [$];
  match_report_t        report_q [$];

  int unsigned          errors = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          in_idle_pct = 0;
  int unsigned          out_stall_pct = 0;
  int unsigned          in_gap = 0;
  int unsigned          out_gap = 0;
  int unsigned          scans_pushed = 0;
  logic                 in_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  masked_byte_pattern_search i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_pattern_length_i (cfg_pattern_length_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .mode_i               (mode_i),
    .element_index_i      (element_index_i),
    .byte_value_i         (byte_value_i),
    .wildcard_req_i       (wildcard_req_i),
    .last_byte_i          (last_byte_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .found_o              (found_o),
    .match_offset_o       (match_offset_o)
  );

  function automatic int unsigned active_len(input logic [CfgW-1:0] raw);
    if (raw == '0) begin
      return 1;
    end else if (32'(raw) > PatternMax) begin
      return PatternMax;
    end
    return 32'(raw);
  endfunction

  task automatic restart_region();
    for (int k = 0; k < PatternMax; k++) window_q[k] = '0;
    seen_q     = '0;
    reported_q = 1'b0;
  endtask

  task automatic search_step(input beat_t b);
    int unsigned   len;
    logic          hit;
    match_report_t rep;
    if (b.mode == ModeLoad) begin
      if (32'(b.idx) < PatternMax) begin
        sig_bytes[b.idx] = b.data;
        sig_wild[b.idx]  = b.wild;
      end
    end else begin
      for (int k = PatternMax - 1; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = b.data;
      if (seen_q != '1) seen_q = seen_q + 1;
      len = active_len(sig_len_q);
      if (!reported_q && seen_q >= len) begin
        hit = 1'b1;
        for (int j = 0; j < len; j++) begin
          if (!sig_wild[j] && sig_bytes[j] != window_q[len-1-j]) hit = 1'b0;
        end
        if (hit) begin
          reported_q = 1'b1;
          rep.found  = 1'b1;
          rep.offset = seen_q - len;
          report_q.push_back(rep);
        end
      end
      if (b.last) begin
        if (!reported_q) begin
          rep.found  = 1'b0;
          rep.offset = '0;
          report_q.push_back(rep);
        end
        restart_region();
      end
    end
  endtask

  // scoreboard, predictor and watchdog
  always @(posedge clk_i) begin : scoreboard
    match_report_t want;
    beat_t         b;
    logic          out_beat;
    if (rst_ni) begin
      out_beat = out_valid_o && out_ready_i;
      in_taken = in_valid_i && in_ready_o;
      if (out_beat) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found %0b offset %0d",
                   $time, found_o, match_offset_o);
          errors++;
        end else begin
          want = report_q.pop_front();
          if (found_o !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, found_o);
            errors++;
          end
          if (match_offset_o !== want.offset) begin
            $display("%0t: match_offset mismatch, expected %0d actual %0d",
                     $time, want.offset, match_offset_o);
            errors++;
          end
        end
      end
      if (in_taken) begin
        b.mode = mode_e'(mode_i);
        b.idx  = element_index_i;
        b.data = byte_value_i;
        b.wild = wildcard_req_i;
        b.last = last_byte_i;
        search_step(b);
      end
      if (cfg_we_i) sig_len_q = cfg_pattern_length_i;
      if (in_taken || out_beat) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("%0t: no beat for %0d cycles", $time, idle_cycles);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin : driver
    beat_t b;
    logic  take;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      take = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (beat_q.size() != 0) begin
        if (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct) begin
          in_gap = $urandom_range(5, 0);
        end else begin
          take = 1'b1;
        end
      end
      if (take) begin
        b = beat_q.pop_front();
        mode_i          <= b.mode;
        element_index_i <= b.idx;
        byte_value_i    <= b.data;
        wildcard_req_i  <= b.wild;
        last_byte_i     <= b.last;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin : sink
    if (out_gap != 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct) begin
      out_gap = $urandom_range(5, 0);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic push_load(input int unsigned idx, input logic [ByteW-1:0] val,
                           input logic wild, input logic last);
    beat_t b;
    b.mode = ModeLoad;
    b.idx  = ElemW'(idx);
    b.data = val;
    b.wild = wild;
    b.last = last;
    gen_bytes[idx] = val;
    gen_wild[idx]  = wild;
    beat_q.push_back(b);
  endtask

  task automatic push_scan(input logic [ByteW-1:0] val, input logic last);
    beat_t b;
    b.mode = ModeScan;
    b.idx  = ElemW'($urandom_range(PatternMax - 1, 0));
    b.data = val;
    b.wild = 1'($urandom_range(1, 0));
    b.last = last;
    beat_q.push_back(b);
    scans_pushed++;
  endtask

  // one region: mostly an embedded match with random wildcard bytes, some near misses, some noise
  task automatic push_region(input int unsigned len);
    int unsigned      rlen;
    int unsigned      kind;
    int unsigned      pos;
    int unsigned      flip;
    int unsigned      j;
    logic [ByteW-1:0] v;
    rlen = ($urandom_range(9, 0) == 0) ? $urandom_range(3 * len + 40, 1)
                                       : $urandom_range(2 * len + 4, 1);
    kind = $urandom_range(9, 0);
    pos  = 0;
    if (rlen >= len) begin
      pos = ($urandom_range(7, 0) == 0) ? rlen - len : $urandom_range(rlen - len, 0);
    end
    flip = $urandom_range(len - 1, 0);
    for (int unsigned i = 0; i < rlen; i++) begin
      if (kind < 8 && rlen >= len && i >= pos && i < pos + len) begin
        j = i - pos;
        v = gen_wild[j] ? ByteW'($urandom) : gen_bytes[j];
        if (kind >= 6 && j == flip) v = v ^ (8'h01 << $urandom_range(7, 0));
      end else begin
        v = ByteW'($urandom);
      end
      if ($urandom_range(49, 0) == 0) begin
        push_load($urandom_range(PatternMax - 1, 0), ByteW'($urandom),
                  1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      end
      push_scan(v, i == rlen - 1);
    end
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0 || in_valid_i || report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CfgW-1:0] len);
    @(negedge clk_i);
    cfg_pattern_length_i <= len;
    cfg_we_i             <= 1'b1;
    @(negedge clk_i);
    cfg_we_i             <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned len_plan [NumPhases];
    int unsigned len;
    len_plan = '{0, 32, 63, 2, 33, 5, 1, 17, 3, 8};
    for (int k = 0; k < PatternMax; k++) begin
      sig_bytes[k] = '0;
      sig_wild[k]  = 1'b0;
    end
    restart_region();
    sig_len_q = CfgW'(1);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // length 1 out of reset
    push_load(0, 8'hFF, 1'b0, 1'b1);
    push_scan(8'h00, 1'b0);
    push_scan(8'hFF, 1'b0);
    push_scan(8'hFF, 1'b0);
    push_scan(8'h12, 1'b1);
    push_scan(8'h00, 1'b1);
    push_scan(8'hFF, 1'b1);
    push_load(0, 8'h00, 1'b1, 1'b0);
    push_scan(8'hAB, 1'b0);
    push_load(0, 8'h5A, 1'b0, 1'b1);
    push_scan(8'h5A, 1'b1);
    push_scan(8'h5A, 1'b0);
    push_scan(8'hA5, 1'b1);
    push_load(PatternMax - 1, 8'hA5, 1'b1, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_length(CfgW'(len_plan[p]));
      len = active_len(CfgW'(len_plan[p]));
      if (p % 3 == 2 || p == NumPhases - 1) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end else begin
        in_idle_pct   = $urandom_range(40, 10);
        out_stall_pct = $urandom_range(40, 10);
      end
      for (int k = 0; k < PatternMax; k++) begin
        push_load(k, ByteW'($urandom), ($urandom_range(3, 0) == 0),
                  1'($urandom_range(1, 0)));
      end
      scans_pushed = 0;
      while (scans_pushed < ScansPerPhase) begin
        if ($urandom_range(5, 0) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            push_load($urandom_range(PatternMax - 1, 0), ByteW'($urandom),
                      1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
          end
        end
        push_region(len);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/mbps_pkg.sv
rtl/core/mbps_pattern_store.sv
rtl/core/mbps_window_match.sv
rtl/core/masked_byte_pattern_search.sv
test/masked_byte_pattern_search_tb.sv
